// ===== rtl/bchd_pkg.sv =====
// Shared types, constants and register indexes of the button click/hold detector.
package bchd_pkg;

  localparam int unsigned TimerBitsDef = 16;
  localparam int unsigned CountBitsDef = 8;

  localparam int unsigned CfgW       = 16;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned ClickW     = 8;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 16;

  localparam logic [CfgW-1:0] HoldTimeRst     = 16'd500;
  localparam logic [CfgW-1:0] SamplePeriodRst = 16'd10;
  localparam logic            InvertRst       = 1'b1;

  typedef enum logic [CfgIndexW-1:0] {
    RegHoldTime     = 2'd0,
    RegSamplePeriod = 2'd1,
    RegInvert       = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CfgW-1:0] hold_time_ms;
    logic [CfgW-1:0] sample_period_ms;
    logic            invert_input;
  } cfg_t;

  typedef struct packed {
    logic [ClickW-1:0] click_count;
    logic              hold_end_event;
    logic              toggle_event;
    logic              release_event;
    logic              press_event;
    logic              holding_now;
    logic              pressed_now;
  } result_t;

endpackage

// ===== rtl/bchd_core.sv =====
// Per-tick state update of the button detector: timers, sampling, flags and click burst.
module bchd_core import bchd_pkg::*; #(
  parameter int unsigned TIMER_BITS = TimerBitsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    pin_level_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  localparam int unsigned CmpW = (TIMER_BITS > CfgW) ? TIMER_BITS : CfgW;
  localparam int unsigned RepW = (COUNT_BITS > ClickW) ? COUNT_BITS : ClickW;
  localparam logic [TIMER_BITS-1:0] TimerMax = {TIMER_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic                  sampled_q, sampled_d;
  logic                  press_q, press_d;
  logic                  hold_q, hold_d;
  logic [COUNT_BITS-1:0] pend_q, pend_d;
  logic [TIMER_BITS-1:0] sample_q, sample_d;
  logic [TIMER_BITS-1:0] holdt_q, holdt_d;
  logic [TIMER_BITS-1:0] burst_q, burst_d;

  logic                  sample_hit, rise, done;
  logic [TIMER_BITS-1:0] sample_inc, holdt_inc, burst_inc;
  logic [COUNT_BITS-1:0] pend_mid;
  logic [RepW-1:0]       rep_wide;
  logic [ClickW-1:0]     report;

  always_comb begin
    sample_inc = (sample_q == TimerMax) ? sample_q : sample_q + 1'b1;
    holdt_inc  = (holdt_q  == TimerMax) ? holdt_q  : holdt_q + 1'b1;
    burst_inc  = (burst_q  == TimerMax) ? burst_q  : burst_q + 1'b1;

    // resample once the counter passes the period
    sample_hit = CmpW'(sample_inc) > CmpW'(cfg_i.sample_period_ms);
    sampled_d  = sample_hit ? (pin_level_i ^ cfg_i.invert_input) : sampled_q;
    sample_d   = sample_hit ? '0 : sample_inc;

    rise     = sampled_d && !press_q;
    pend_mid = rise ? ((pend_q == CountMax) ? pend_q : pend_q + 1'b1) : pend_q;
    holdt_d  = rise ? '0 : holdt_inc;
    burst_d  = rise ? '0 : burst_inc;

    done   = (pend_mid != '0) && (CmpW'(burst_d) > CmpW'(cfg_i.hold_time_ms));
    pend_d = done ? '0 : pend_mid;

    press_d = sampled_d;
    if (!sampled_d && press_q) begin
      hold_d = 1'b0;
    end else begin
      hold_d = hold_q | (sampled_d && (CmpW'(holdt_d) > CmpW'(cfg_i.hold_time_ms)));
    end

    rep_wide = done ? RepW'(pend_mid) : '0;
    if (hold_d) begin
      report = '0;
    end else if (rep_wide > RepW'(8'hFF)) begin
      report = 8'hFF;
    end else begin
      report = rep_wide[ClickW-1:0];
    end
  end

  always_comb begin
    result_o.pressed_now    = press_d;
    result_o.holding_now    = hold_d;
    result_o.press_event    = press_d && !press_q;
    result_o.release_event  = !press_d && press_q;
    result_o.toggle_event   = press_d ^ press_q;
    result_o.hold_end_event = !hold_d && hold_q;
    result_o.click_count    = report;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sampled_q <= 1'b0;
      press_q   <= 1'b0;
      hold_q    <= 1'b0;
      pend_q    <= '0;
      sample_q  <= '0;
      holdt_q   <= '0;
      burst_q   <= '0;
    end else if (step_i) begin
      sampled_q <= sampled_d;
      press_q   <= press_d;
      hold_q    <= hold_d;
      pend_q    <= pend_d;
      sample_q  <= sample_d;
      holdt_q   <= holdt_d;
      burst_q   <= burst_d;
    end
  end

endmodule

// ===== rtl/button_click_hold_detector.sv =====
// A result item appears on the master side in the cycle after its tick item is accepted.
// Throughput: one tick item per cycle when not stalled; the state update is a single registered pass.
// The input side stalls only while a result waits in the output register.
// Reset: all flags, timers and click counts clear; registers load hold time 500,
// sample period 10 and inverted input.
module button_click_hold_detector import bchd_pkg::*; #(
  parameter int unsigned TIMER_BITS = TimerBitsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,   // [0] pin_level
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] pressed_now, [1] holding_now, [2] press_event, [3] release_event,
  // [4] toggle_event, [5] hold_end_event, [13:6] click_count
  output logic [OutDataW-1:0]  m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]      cfg_data_i
);

  cfg_t    cfg_q;
  result_t result;
  result_t out_q;
  logic    out_valid_q;
  logic    accept;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_time_ms     <= HoldTimeRst;
      cfg_q.sample_period_ms <= SamplePeriodRst;
      cfg_q.invert_input     <= InvertRst;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegHoldTime:     cfg_q.hold_time_ms     <= cfg_data_i;
        RegSamplePeriod: cfg_q.sample_period_ms <= cfg_data_i;
        RegInvert:       cfg_q.invert_input     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  bchd_core #(
    .TIMER_BITS(TIMER_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .pin_level_i (s_axis_tdata[0]),
    .cfg_i       (cfg_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  // hold the result while the master side stalls
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, out_q};

endmodule

// ===== rtl/bchd_checker.sv =====
// Port-level checks of the button detector, bound to the top level.
module bchd_checker import bchd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input item taken while output register full");

  a_item_yields_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  a_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4] == (m_axis_tdata[2] || m_axis_tdata[3]))
                      && !(m_axis_tdata[2] && m_axis_tdata[3]))
    else $error("toggle does not match press and release");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0] && (m_axis_tdata[13:6] == 8'd0))
    else $error("holding without press or with a click count");

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the button click/hold detector: tick stream in, results checked.
module tb_top;
  import bchd_pkg::*;

  localparam logic [CfgIndexW-1:0] RegUnmapped = 2'd3;
  localparam int unsigned IdleMax = 12;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]      cfg_data_i = '0;

  button_click_hold_detector i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // Detector state as the checker sees it.
  cfg_t                    det_cfg = '{HoldTimeRst, SamplePeriodRst, InvertRst};
  logic                    level_pressed = 1'b0;
  logic                    press_q = 1'b0;
  logic                    hold_q = 1'b0;
  logic                    press_d = 1'b0;
  logic                    hold_d = 1'b0;
  logic [CountBitsDef-1:0] clicks_open = '0;
  logic [CountBitsDef-1:0] clicks_out = '0;
  logic [TimerBitsDef-1:0] sample_ms = '0;
  logic [TimerBitsDef-1:0] hold_ms = '0;
  logic [TimerBitsDef-1:0] burst_ms = '0;

  bit          staged_pins[$];
  bit          pending_pins[$];
  result_t     expected_reports[$];
  int unsigned mismatch_count = 0;
  bit          tick_taken = 1'b0;
  bit          allow_idle = 1'b1;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic logic [TimerBitsDef-1:0] timer_inc(input logic [TimerBitsDef-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  task automatic advance_detector(input logic pin);
    result_t r;
    sample_ms = timer_inc(sample_ms);
    hold_ms   = timer_inc(hold_ms);
    burst_ms  = timer_inc(burst_ms);
    if (sample_ms > det_cfg.sample_period_ms) begin
      level_pressed = pin ^ det_cfg.invert_input;
      sample_ms = '0;
    end
    clicks_out = '0;
    if (level_pressed && !press_q) begin
      press_q = 1'b1;
      clicks_open = (&clicks_open) ? clicks_open : clicks_open + 1'b1;
      hold_ms = '0;
      burst_ms = '0;
    end
    if (clicks_open != '0 && burst_ms > det_cfg.hold_time_ms) begin
      clicks_out = clicks_open;
      clicks_open = '0;
    end
    if (level_pressed && hold_ms > det_cfg.hold_time_ms) hold_q = 1'b1;
    if (!level_pressed && press_q) begin
      press_q = 1'b0;
      hold_q = 1'b0;
    end
    r.pressed_now    = press_q;
    r.holding_now    = hold_q;
    r.press_event    = press_q && !press_d;
    r.release_event  = !press_q && press_d;
    r.toggle_event   = press_q != press_d;
    r.hold_end_event = !hold_q && hold_d;
    // a burst that ends while holding reports nothing
    r.click_count    = hold_q ? '0 : clicks_out;
    press_d = press_q;
    hold_d  = hold_q;
    expected_reports.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic check_report(input logic [OutDataW-1:0] raw);
    result_t got;
    result_t want;
    got = result_t'(raw[$bits(result_t)-1:0]);
    if (expected_reports.size() == 0) begin
      report_mismatch("result with none pending", 32'(raw), 0);
    end else begin
      want = expected_reports.pop_front();
      if (got.pressed_now != want.pressed_now)
        report_mismatch("pressed_now", 32'(got.pressed_now), 32'(want.pressed_now));
      if (got.holding_now != want.holding_now)
        report_mismatch("holding_now", 32'(got.holding_now), 32'(want.holding_now));
      if (got.press_event != want.press_event)
        report_mismatch("press_event", 32'(got.press_event), 32'(want.press_event));
      if (got.release_event != want.release_event)
        report_mismatch("release_event", 32'(got.release_event), 32'(want.release_event));
      if (got.toggle_event != want.toggle_event)
        report_mismatch("toggle_event", 32'(got.toggle_event), 32'(want.toggle_event));
      if (got.hold_end_event != want.hold_end_event)
        report_mismatch("hold_end_event", 32'(got.hold_end_event),
                        32'(want.hold_end_event));
      if (got.click_count != want.click_count)
        report_mismatch("click_count", 32'(got.click_count), 32'(want.click_count));
      if (raw[OutDataW-1:$bits(result_t)] != '0)
        report_mismatch("pad bits", 32'(raw[OutDataW-1:$bits(result_t)]), 0);
    end
  endtask

  // Tick item accepted: advance the model and drop it from the send queue.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      advance_detector(s_axis_tdata[0]);
      void'(pending_pins.pop_front());
      tick_taken = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_report(m_axis_tdata);
  end

  always @(negedge clk_i) begin
    // hold an offered item until it is taken
    if (rst_ni && !(s_axis_tvalid && !tick_taken)) begin
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (allow_idle && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, IdleMax) - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pins.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(InDataW-1){1'b0}}, pending_pins[0]};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    tick_taken = 1'b0;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (recv_stall != 0) begin
      recv_stall--;
      m_axis_tready <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 7) == 0) begin
      recv_stall = $urandom_range(1, IdleMax) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegHoldTime:     det_cfg.hold_time_ms = value;
      RegSamplePeriod: det_cfg.sample_period_ms = value;
      RegInvert:       det_cfg.invert_input = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic stage_level(input bit pressed, input int unsigned ticks);
    repeat (ticks) staged_pins.push_back(pressed ^ det_cfg.invert_input);
  endtask

  // Mostly click bursts with random press and gap lengths, some raw noise.
  task automatic stage_random(input int unsigned n);
    int unsigned per;
    int unsigned hold;
    int unsigned start;
    per   = 32'(det_cfg.sample_period_ms) + 1;
    hold  = 32'(det_cfg.hold_time_ms);
    start = staged_pins.size();
    while (staged_pins.size() - start < n) begin
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 3) == 0) stage_level(1'b1, hold + $urandom_range(1, 3 * per));
          else stage_level(1'b1, $urandom_range(1, 3 * per));
          stage_level(1'b0, $urandom_range(1, 2 * per) + $urandom_range(0, hold / 2));
        end
        stage_level(1'b0, hold + 2 * per + $urandom_range(0, 3));
      end else begin
        repeat ($urandom_range(1, 20)) staged_pins.push_back(bit'($urandom_range(0, 1)));
      end
    end
  endtask

  // Hand the staged ticks to the driver and wait until every result is back.
  task automatic play_staged(input bit idle_on);
    @(posedge clk_i);
    allow_idle = idle_on;
    pending_pins = staged_pins;
    staged_pins.delete();
    do @(negedge clk_i); while (pending_pins.size() != 0 || expected_reports.size() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(RegUnmapped, 16'hFFFF);
    stage_level(1'b1, 12);
    stage_level(1'b0, 12);
    play_staged(1'b1);

    // zero hold time, resample every tick, active-high pin
    write_reg(RegHoldTime, 16'd0);
    write_reg(RegSamplePeriod, 16'd0);
    write_reg(RegInvert, 16'd0);
    stage_level(1'b1, 3);
    stage_level(1'b0, 2);
    stage_level(1'b1, 1);
    stage_level(1'b0, 3);
    play_staged(1'b1);

    // drive the pending click count into saturation
    write_reg(RegHoldTime, 16'd20);
    write_reg(RegInvert, 16'd1);
    repeat (260) begin
      stage_level(1'b1, 1);
      stage_level(1'b0, 1);
    end
    stage_level(1'b0, 24);
    play_staged(1'b1);

    // largest period: the sample counter never exceeds it
    write_reg(RegSamplePeriod, 16'hFFFF);
    write_reg(RegHoldTime, 16'd3);
    repeat (40) staged_pins.push_back(bit'($urandom_range(0, 1)));
    play_staged(1'b1);

    for (int p = 0; p < 5; p++) begin
      write_reg(RegHoldTime, CfgW'($urandom_range(0, 40)));
      write_reg(RegSamplePeriod, CfgW'($urandom_range(0, 4)));
      write_reg(RegInvert, CfgW'($urandom_range(0, 1)));
      stage_random(40);
      play_staged(p != 4);
    end

    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
